// ----- hw/rtl/fpba_pkg.sv -----
// Shared constants, codes and transaction types of the fit-policy block allocator.
package fpba_pkg;

  localparam int NUM_BLOCKS   = 16;
  localparam int SIZE_WIDTH   = 16;
  localparam int MAX_REQUESTS = 256;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = 8;
  localparam int CFG_W = 5;

  localparam logic [CNT_W-1:0] CNT_LIMIT =
    CNT_W'((MAX_REQUESTS - 1 < 255) ? MAX_REQUESTS - 1 : 255);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic CFG_FIT_POLICY    = 1'b0;
  localparam logic CFG_BLOCKS_IN_USE = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [3:0]            block_index;
    logic [SIZE_WIDTH-1:0] size;
  } item_t;

  typedef struct packed {
    logic                  granted;
    logic [3:0]            chosen_block;
    logic [SIZE_WIDTH-1:0] remaining_after;
    logic [CNT_W-1:0]      request_number;
  } result_t;

endpackage

// ----- hw/rtl/fpba_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface fpba_item_if import fpba_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fpba_result_if import fpba_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/fit_policy_block_allocator_top.sv -----
// Fit-policy block allocator: free-size table in RAM, scanned once per allocate.
// A load writes its entry in the cycle it is accepted, and the next transaction follows at once.
// An allocate scans N = min(blocks_in_use, 16) entries in state SCAN (skipped when N is 0), then
// in state WB writes back the pick's remainder and its result once the output register is free;
// input is taken again in IDLE. A waiting result sits in an output register while input goes on.
// Synchronous reset clears control, policy, blocks_in_use (16) and count; table undefined.
module fit_policy_block_allocator_top import fpba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  fpba_item_if.sink        items,
  fpba_result_if.source    results,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  logic [1:0]            state;
  logic [1:0]            fit_policy;
  logic [CFG_W-1:0]      blocks_in_use;
  logic [CNT_W-1:0]      req_count;
  logic [SIZE_WIDTH-1:0] req_size;
  logic [IDX_W:0]        scan_len;
  logic [IDX_W:0]        rd_ptr;
  logic                  rd_pend;
  logic [IDX_W-1:0]      ev_idx;
  logic                  found;
  logic [SIZE_WIDTH-1:0] best_val;
  logic [IDX_W-1:0]      best_idx;
  logic                  res_valid;
  result_t               res_data;

  logic                  accept;
  logic                  slot_free;
  logic [IDX_W:0]        scan_len_next;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [SIZE_WIDTH-1:0] ram_wdata;
  logic [SIZE_WIDTH-1:0] ram_rdata;
  logic                  take;
  logic [SIZE_WIDTH-1:0] remain;

  assign items.ready   = (state == ST_IDLE);
  assign accept        = items.valid && items.ready;
  assign slot_free     = !res_valid || results.ready;
  assign results.valid = res_valid;
  assign results.data  = res_data;
  assign remain        = best_val - req_size;

  // Clamp the search length to the table depth.
  assign scan_len_next = (blocks_in_use > CFG_W'(NUM_BLOCKS)) ?
                         (IDX_W+1)'(NUM_BLOCKS) : (IDX_W+1)'(blocks_in_use);

  // Policy three falls through to first fit: never replaces a pick.
  assign take = (ram_rdata >= req_size) &&
                (!found ||
                 (fit_policy == POL_BEST  && ram_rdata < best_val) ||
                 (fit_policy == POL_WORST && ram_rdata > best_val));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = items.data.block_index[IDX_W-1:0];
    ram_wdata = items.data.size;
    if (accept && items.data.op == OP_LOAD &&
        ({1'b0, items.data.block_index} < 5'(NUM_BLOCKS))) begin
      ram_we = 1'b1;
    end else if (state == ST_WB && slot_free && found) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx;
      ram_wdata = remain;
    end
  end

  fpba_ram #(
    .WIDTH (SIZE_WIDTH),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy    <= POL_FIRST;
      blocks_in_use <= CFG_W'(NUM_BLOCKS);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIT_POLICY:    fit_policy    <= cfg_data[1:0];
        CFG_BLOCKS_IN_USE: blocks_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      req_count <= '0;
      rd_ptr    <= '0;
      rd_pend   <= 1'b0;
      found     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (results.ready && state != ST_WB) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          rd_ptr  <= '0;
          rd_pend <= 1'b0;
          if (accept) begin
            if (items.data.op == OP_LOAD) begin
              req_count <= '0;
            end else begin
              if (req_count < CNT_LIMIT) begin
                req_count <= req_count + 1'b1;
              end
              req_size <= items.data.size;
              scan_len <= scan_len_next;
              found    <= 1'b0;
              state    <= (scan_len_next == '0) ? ST_WB : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle, evaluate the entry read last cycle.
          if (rd_ptr < scan_len) begin
            rd_ptr  <= rd_ptr + 1'b1;
            ev_idx  <= rd_ptr[IDX_W-1:0];
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend && take) begin
            found    <= 1'b1;
            best_val <= ram_rdata;
            best_idx <= ev_idx;
          end
          if (rd_ptr == scan_len && !rd_pend) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          // Hold until the output register can take the result.
          if (slot_free) begin
            res_valid                <= 1'b1;
            res_data.granted         <= found;
            res_data.chosen_block    <= found ? 4'(best_idx) : 4'd0;
            res_data.remaining_after <= found ? remain : '0;
            res_data.request_number  <= req_count;
            state                    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/fpba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/fpba_checker.sv -----
// Port-level assertions for the fit-policy block allocator, bound to the top level.
module fpba_checker import fpba_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_op,
  input logic            out_valid,
  input logic            out_granted,
  input logic [3:0]      out_block,
  input logic [15:0]     out_remaining,
  input logic [CNT_W-1:0] out_number
);

  // A refused request reports no block and no size.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_granted) |-> (out_block == 4'd0 && out_remaining == 16'd0))
    else $error("refused result carries block or size");

  // Every result counts at least its own request.
  a_number_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_number != '0))
    else $error("result request number is zero");

  // An accepted allocate occupies the block for the scan.
  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_op == OP_ALLOC) |=> !in_ready)
    else $error("ready right after an accepted allocate");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind fit_policy_block_allocator_top fpba_checker u_fpba_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (items.valid),
  .in_ready      (items.ready),
  .in_op         (items.data.op),
  .out_valid     (results.valid),
  .out_granted   (results.data.granted),
  .out_block     (results.data.chosen_block),
  .out_remaining (results.data.remaining_after),
  .out_number    (results.data.request_number)
);

// ----- test/fpba_grant_checker.sv -----
`timescale 1ns / 100ps
// Allocation checker: tracks the free-size table, predicts each grant and compares the results.
module fpba_grant_checker import fpba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  fpba_item_if             items,
  fpba_result_if           results,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);

  logic [SIZE_WIDTH-1:0] free_sizes [NUM_BLOCKS];
  logic [1:0]            fit_mode;
  logic [CFG_W-1:0]      search_len;
  logic [CNT_W-1:0]      alloc_count;
  result_t               grant_queue [$];
  int                    fail_count = 0;
  int                    queued = 0;

  assign errors  = fail_count;
  assign pending = queued;

  // Search the table under the current policy and carve the request out of the pick.
  function automatic result_t predict_grant(logic [SIZE_WIDTH-1:0] req);
    int      span;
    int      pick;
    bit      found;
    result_t r;
    if (alloc_count < CNT_LIMIT) alloc_count++;
    span  = (int'(search_len) > NUM_BLOCKS) ? NUM_BLOCKS : int'(search_len);
    found = 1'b0;
    pick  = 0;
    for (int j = 0; j < span; j++) begin
      if (free_sizes[j] >= req) begin
        if (!found) begin
          found = 1'b1;
          pick  = j;
          if (fit_mode != POL_BEST && fit_mode != POL_WORST) break;
        end else if (fit_mode == POL_BEST && free_sizes[j] < free_sizes[pick]) begin
          pick = j;
        end else if (fit_mode == POL_WORST && free_sizes[j] > free_sizes[pick]) begin
          pick = j;
        end
      end
    end
    r = '0;
    r.request_number = alloc_count;
    if (found) begin
      free_sizes[pick]  = free_sizes[pick] - req;
      r.granted         = 1'b1;
      r.chosen_block    = 4'(pick);
      r.remaining_after = free_sizes[pick];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      fit_mode    = POL_FIRST;
      search_len  = CFG_W'(NUM_BLOCKS);
      alloc_count = '0;
      grant_queue.delete();
    end else begin
      if (results.valid && results.ready) begin
        got = results.data;
        if (grant_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: granted=%0d block=%0d remaining=%0d request=%0d",
                     got.granted, got.chosen_block, got.remaining_after, got.request_number);
        end else begin
          want = grant_queue.pop_front();
          if (got.granted !== want.granted || got.chosen_block !== want.chosen_block ||
              got.remaining_after !== want.remaining_after ||
              got.request_number !== want.request_number) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: expected granted=%0d block=%0d remaining=%0d request=%0d,",
                        " got granted=%0d block=%0d remaining=%0d request=%0d"},
                       want.granted, want.chosen_block, want.remaining_after,
                       want.request_number, got.granted, got.chosen_block,
                       got.remaining_after, got.request_number);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIT_POLICY:    fit_mode = cfg_data[1:0];
          CFG_BLOCKS_IN_USE: search_len = cfg_data;
          default: ;
        endcase
      end
      if (items.valid && items.ready) begin
        if (items.data.op == OP_LOAD) begin
          if (int'(items.data.block_index) < NUM_BLOCKS)
            free_sizes[items.data.block_index] = items.data.size;
          alloc_count = '0;
        end else begin
          grant_queue.push_back(predict_grant(items.data.size));
        end
      end
    end
    queued = grant_queue.size();
  end

endmodule

// ----- test/fit_policy_block_allocator_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus and verdict for the fit-policy block allocator.
module fit_policy_block_allocator_top_tb import fpba_pkg::*; ();

  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_WAIT  = 25;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_FIT_POLICY;
  logic [CFG_W-1:0] cfg_data = '0;
  int               errors;
  int               pending;
  bit               idle_on = 1'b1;
  bit               hold_request = 1'b0;
  int               hold_left;
  int               stuck_cycles = 0;

  fpba_item_if   item_ch ();
  fpba_result_if result_ch ();

  fit_policy_block_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .items     (item_ch),
    .results   (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fpba_grant_checker grant_check (
    .clk       (clk),
    .rst       (rst),
    .items     (item_ch),
    .results   (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  // Result side: random back-pressure, plus one long hold on request.
  initial begin
    result_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= !(idle_on && $urandom_range(99) < 8);
      end
    end
  end

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("[fit_policy_block_allocator_top] ERROR");
        $finish;
      end
    end
  end

  // Offer one transaction and return at the falling edge after it is taken.
  task automatic push_item(logic op, logic [3:0] idx, logic [SIZE_WIDTH-1:0] sz);
    item_t it;
    it = {op, idx, sz};
    if (idle_on && $urandom_range(99) < 8) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
  endtask

  // Drain all grants, then give the block time to finish before touching registers.
  task automatic settle();
    item_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [SIZE_WIDTH-1:0] random_size(int span_max);
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0:       return '0;
      1:       return '1;
      2, 3, 4: return SIZE_WIDTH'($urandom_range(1, span_max));
      default: return SIZE_WIDTH'($urandom);
    endcase
  endfunction

  initial begin
    int               n_items;
    logic [1:0]       pol;
    logic [CFG_W-1:0] blk;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill every entry before any search can read it.
    for (int i = 0; i < NUM_BLOCKS; i++)
      push_item(OP_LOAD, 4'(i), (i == 0) ? 16'h0000 : (i == 15) ? 16'hFFFF : 16'(i * 3001));
    push_item(OP_ALLOC, 4'hF, 16'h0000);   // zero request lands on the empty entry
    push_item(OP_ALLOC, 4'h0, 16'hFFFF);
    push_item(OP_ALLOC, 4'hA, 16'hFFFF);   // refused, still counted
    push_item(OP_ALLOC, 4'h5, 16'd5000);
    settle();
    write_reg(CFG_FIT_POLICY, CFG_W'(POL_BEST));
    push_item(OP_ALLOC, 4'h3, 16'd1000);
    settle();
    write_reg(CFG_FIT_POLICY, CFG_W'(POL_WORST));
    push_item(OP_ALLOC, 4'hC, 16'd100);
    settle();
    write_reg(CFG_FIT_POLICY, 5'b11111);   // unused policy code behaves as first fit
    write_reg(CFG_BLOCKS_IN_USE, 5'd0);
    push_item(OP_ALLOC, 4'h1, 16'h0000);
    settle();
    write_reg(CFG_BLOCKS_IN_USE, 5'd31);
    push_item(OP_ALLOC, 4'h2, 16'd40000);
    push_item(OP_ALLOC, 4'h7, 16'd1);
    settle();
    write_reg(CFG_BLOCKS_IN_USE, 5'd1);
    push_item(OP_ALLOC, 4'h9, 16'h0000);

    for (int ph = 0; ph < 12; ph++) begin
      settle();
      pol = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
      case (ph)
        0:       blk = 5'd16;
        1:       blk = 5'd1;
        2:       blk = 5'd31;
        3:       blk = 5'd16;
        4:       blk = 5'd8;
        5:       blk = 5'd17;
        default: blk = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(1, 16));
      endcase
      write_reg(CFG_FIT_POLICY, {3'($urandom_range(0, 7)), pol});
      write_reg(CFG_BLOCKS_IN_USE, blk);
      idle_on = !(ph == 6 || ph == 7);
      // Phase 3 runs without loads so the request count saturates.
      n_items = (ph == 3) ? 300 : 130;
      for (int k = 0; k < n_items; k++) begin
        if (ph == 4 && k == 40) hold_request = 1'b1;
        if (ph != 3 && $urandom_range(99) < 20)
          push_item(OP_LOAD, 4'($urandom_range(0, 15)), random_size(65535));
        else
          push_item(OP_ALLOC, 4'($urandom), random_size(3000));
      end
    end

    item_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("[fit_policy_block_allocator_top] OK");
    else
      $display("[fit_policy_block_allocator_top] ERROR");
    $finish;
  end

endmodule
